// File: src/sws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types, codes and sizes of the sliding window sender.
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int SEQ_BITS     = 16;
  localparam int PAY_BITS     = 64;
  // slot of a sequence number is its low bits, so the depth is a power of two
  localparam int BUFFER_DEPTH = 8;
  localparam int SLOT_BITS    = $clog2(BUFFER_DEPTH);
  localparam int ENTRY_BITS   = SEQ_BITS + PAY_BITS;
  localparam int WSIZE_BITS   = 3;
  localparam int DUP_BITS     = 3;
  localparam int MAX_RESULTS  = 3;
  localparam int CNT_BITS     = $clog2(MAX_RESULTS + 1);

  localparam logic [WSIZE_BITS-1:0] WSIZE_RESET     = WSIZE_BITS'(4);
  localparam logic [DUP_BITS-1:0]   DUP_FIRST       = DUP_BITS'(1);
  localparam logic [DUP_BITS-1:0]   FAST_RETX_COUNT = DUP_BITS'(4);
  localparam logic [DUP_BITS-1:0]   DUP_COUNT_MAX   = DUP_BITS'(7);

  typedef logic [SEQ_BITS-1:0]   seq_t;
  typedef logic [PAY_BITS-1:0]   pay_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [ENTRY_BITS-1:0] entry_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  typedef enum logic [1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_STATUS   = 2'd0,
    KIND_TRANSMIT = 2'd1,
    KIND_START    = 2'd2,
    KIND_STOP     = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e kind;
    seq_t  seq;
    pay_t  payload;
    logic  accepted;
  } res_t;

  typedef struct packed {
    logic                        load;
    cnt_t                        count;
    res_t [MAX_RESULTS-1:0]      res;
  } emit_req_t;

  function automatic res_t mk_res(kind_e kind, seq_t seq, pay_t pay, logic acc);
    res_t r;
    r.kind     = kind;
    r.seq      = seq;
    r.payload  = pay;
    r.accepted = acc;
    return r;
  endfunction

endpackage

// File: src/sws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sws_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_emit
// Result buffer: takes up to three results at once and hands them out one
// beat at a time on the output channel.
// ----------------------------------------------------------------------------
module sws_emit
  import sws_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  emit_req_t req_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output logic [1:0]          out_kind_o,
  output logic [SEQ_BITS-1:0] seq_number_o,
  output logic [PAY_BITS-1:0] packet_payload_o,
  output logic                accepted_o,
  output logic                last_result_o
);

  res_t [MAX_RESULTS-1:0] res_q, res_d;
  cnt_t                   cnt_q, cnt_d;
  logic                   beat;

  assign out_valid_o = (cnt_q != '0);
  assign beat        = out_valid_o && !out_stall_i;
  // free now, or the last result leaves in this cycle
  assign ready_o     = (cnt_q == '0) || ((cnt_q == cnt_t'(1)) && !out_stall_i);

  always_comb begin
    res_d = res_q;
    cnt_d = cnt_q;
    if (req_i.load) begin
      res_d = req_i.res;
      cnt_d = req_i.count;
    end else if (beat) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
      cnt_d = cnt_q - cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_kind_o       = res_q[0].kind;
  assign seq_number_o     = res_q[0].seq;
  assign packet_payload_o = res_q[0].payload;
  assign accepted_o       = res_q[0].accepted;
  assign last_result_o    = (cnt_q == cnt_t'(1));

`ifndef NO_ASSERTIONS
  a_load_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.load |-> ready_o)
    else $error("result load while buffer busy");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.load |=> out_valid_o)
    else $error("loaded results not presented");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && last_result_o && !req_i.load) |=> !out_valid_o)
    else $error("beat after last result");
`endif

endmodule

// File: src/sws_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_engine
// Command sequencer: window state, duplicate ack tracking and access to the
// retransmit buffer memory.
// ----------------------------------------------------------------------------
module sws_engine
  import sws_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            command_i,
  input  logic [PAY_BITS-1:0]   payload_i,
  input  logic [SEQ_BITS-1:0]   ack_number_i,
  input  logic                  checksum_ok_i,
  input  logic [SEQ_BITS-1:0]   timer_seq_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [WSIZE_BITS-1:0] cfg_window_size_i,
  input  logic                  emit_ready_i,
  output emit_req_t             emit_req_o,
  output logic                  ram_we_o,
  output slot_t                 ram_waddr_o,
  output entry_t                ram_wdata_o,
  output logic                  ram_re_o,
  output slot_t                 ram_raddr_o,
  input  entry_t                ram_rdata_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  seq_t base_q, base_d;
  seq_t next_q, next_d;
  logic full_q, full_d;
  seq_t dval_q, dval_d;
  logic dv_q, dv_d;
  logic [DUP_BITS-1:0]   dcnt_q, dcnt_d;
  logic [WSIZE_BITS-1:0] wsize_q;

  // latched command fields
  logic [1:0] cmd_q;
  pay_t       pay_q;
  seq_t       ack_q;
  logic       ck_q;
  seq_t       tseq_q;

  seq_t win, inflight, ack_off, next_inc, ack_inc, in_ack_inc;
  seq_t rd_seq;
  pay_t rd_pay;
  res_t [MAX_RESULTS-1:0] res;
  cnt_t count;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // retransmit slot is read as the command is taken, data is back in exec
  assign in_ack_inc  = ack_number_i + seq_t'(1);
  assign ram_re_o    = (state_q == ST_IDLE) && in_valid_i;
  assign ram_raddr_o = (command_i == CMD_TIMEOUT) ? timer_seq_i[SLOT_BITS-1:0]
                                                  : in_ack_inc[SLOT_BITS-1:0];
  assign rd_seq      = ram_rdata_i[ENTRY_BITS-1 -: SEQ_BITS];
  assign rd_pay      = ram_rdata_i[PAY_BITS-1:0];

  assign ram_waddr_o = next_q[SLOT_BITS-1:0];
  assign ram_wdata_o = {next_q, pay_q};

  always_comb begin
    if (SEQ_BITS'(wsize_q) < SEQ_BITS'(BUFFER_DEPTH)) begin
      win = SEQ_BITS'(wsize_q);
    end else begin
      win = SEQ_BITS'(BUFFER_DEPTH);
    end
  end

  assign inflight = next_q - base_q;
  assign ack_off  = ack_q - base_q;
  assign next_inc = next_q + seq_t'(1);
  assign ack_inc  = ack_q + seq_t'(1);

  always_comb begin
    state_d  = state_q;
    base_d   = base_q;
    next_d   = next_q;
    full_d   = full_q;
    dval_d   = dval_q;
    dv_d     = dv_q;
    dcnt_d   = dcnt_q;
    ram_we_o = 1'b0;
    res      = '0;
    count    = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (emit_ready_i) begin
          state_d = ST_IDLE;
          case (cmd_q)
            CMD_SEND: begin
              if (full_q || (inflight >= win)) begin
                res[0] = mk_res(KIND_STATUS, next_q, '0, 1'b0);
                count  = cnt_t'(1);
              end else begin
                ram_we_o = 1'b1;
                if (base_q == next_q) begin
                  res[0] = mk_res(KIND_START, next_q, '0, 1'b0);
                  res[1] = mk_res(KIND_TRANSMIT, next_q, pay_q, 1'b0);
                  res[2] = mk_res(KIND_STATUS, next_q, '0, 1'b1);
                  count  = cnt_t'(3);
                end else begin
                  res[0] = mk_res(KIND_TRANSMIT, next_q, pay_q, 1'b0);
                  res[1] = mk_res(KIND_STATUS, next_q, '0, 1'b1);
                  count  = cnt_t'(2);
                end
                next_d = next_inc;
                if ((next_inc - base_q) == win) begin
                  full_d = 1'b1;
                end
              end
            end
            CMD_ACK: begin
              if (ck_q) begin
                if (ack_off < inflight) begin
                  base_d = ack_inc;
                  res[0] = mk_res(KIND_STOP, base_q, '0, 1'b0);
                  if (ack_inc == next_q) begin
                    full_d = 1'b0;
                    count  = cnt_t'(1);
                  end else begin
                    res[1] = mk_res(KIND_START, ack_inc, '0, 1'b0);
                    count  = cnt_t'(2);
                  end
                end else if (dv_q && (dval_q == ack_q)) begin
                  if (dcnt_q < DUP_COUNT_MAX) begin
                    dcnt_d = dcnt_q + DUP_BITS'(1);
                    if (dcnt_d == FAST_RETX_COUNT) begin
                      res[0] = mk_res(KIND_STOP, ack_inc, '0, 1'b0);
                      res[1] = mk_res(KIND_START, ack_inc, '0, 1'b0);
                      res[2] = mk_res(KIND_TRANSMIT, rd_seq, rd_pay, 1'b0);
                      count  = cnt_t'(3);
                    end
                  end
                end else begin
                  dval_d = ack_q;
                  dv_d   = 1'b1;
                  dcnt_d = DUP_FIRST;
                end
              end
            end
            CMD_TIMEOUT: begin
              res[0] = mk_res(KIND_STOP, tseq_q, '0, 1'b0);
              res[1] = mk_res(KIND_START, tseq_q, '0, 1'b0);
              res[2] = mk_res(KIND_TRANSMIT, rd_seq, rd_pay, 1'b0);
              count  = cnt_t'(3);
            end
            default: begin
              count = '0;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    emit_req_o.load  = (count != '0);
    emit_req_o.count = count;
    emit_req_o.res   = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      base_q  <= '0;
      next_q  <= '0;
      full_q  <= 1'b0;
      dval_q  <= '0;
      dv_q    <= 1'b0;
      dcnt_q  <= '0;
      wsize_q <= WSIZE_RESET;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      next_q  <= next_d;
      full_q  <= full_d;
      dval_q  <= dval_d;
      dv_q    <= dv_d;
      dcnt_q  <= dcnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        wsize_q <= cfg_window_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      cmd_q  <= command_i;
      pay_q  <= payload_i;
      ack_q  <= ack_number_i;
      ck_q   <= checksum_ok_i;
      tseq_q <= timer_seq_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_write_on_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q == ST_EXEC) && (cmd_q == CMD_SEND))
    else $error("buffer write outside a send");

  a_flight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight <= seq_t'(BUFFER_DEPTH))
    else $error("more packets in flight than buffer slots");

  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (next_q != base_q))
    else $error("window full with nothing in flight");

  a_load_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_req_o.load |-> (emit_req_o.count != '0) && (state_q == ST_EXEC))
    else $error("empty result load");
`endif

endmodule

// File: src/sliding_window_sender_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_sender_top
// Go-back-N sender window with fast retransmit and a retransmit buffer.
//
// Input channel (in_valid_i / in_stall_o) takes one command a beat: send,
// ack or timeout. The output channel (out_valid_o / out_stall_i) gives zero
// to three result beats per command, last_result_o marking the final one.
// The config channel writes window_size whenever cfg_valid_i is high; the
// user must see that it is written only while the block is idle, as the
// block does not enforce this. A taken command is latched; the exec state
// builds its results and, once the result buffer is free, registers them
// into it for the output. A new command can be taken while earlier results
// still drain; the pace is set by the registered read of the retransmit
// memory and by the buffer handing out one beat per cycle unless stalled.
// Reset clears the window, the duplicate ack tracking and sets window_size
// to 4; buffer contents are left as they are. While the receiver stalls the
// held result stays put, one more command may be taken and then in_stall_o
// rises until the buffer drains.
// ----------------------------------------------------------------------------
module sliding_window_sender_top
  import sws_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            command_i,
  input  logic [PAY_BITS-1:0]   payload_i,
  input  logic [SEQ_BITS-1:0]   ack_number_i,
  input  logic                  checksum_ok_i,
  input  logic [SEQ_BITS-1:0]   timer_seq_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            out_kind_o,
  output logic [SEQ_BITS-1:0]   seq_number_o,
  output logic [PAY_BITS-1:0]   packet_payload_o,
  output logic                  accepted_o,
  output logic                  last_result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [WSIZE_BITS-1:0] cfg_window_size_i
);

  emit_req_t emit_req;
  logic      emit_ready;
  logic      ram_we, ram_re;
  slot_t     ram_waddr, ram_raddr;
  entry_t    ram_wdata, ram_rdata;

  sws_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sws_engine u_engine (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .payload_i         (payload_i),
    .ack_number_i      (ack_number_i),
    .checksum_ok_i     (checksum_ok_i),
    .timer_seq_i       (timer_seq_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_window_size_i (cfg_window_size_i),
    .emit_ready_i      (emit_ready),
    .emit_req_o        (emit_req),
    .ram_we_o          (ram_we),
    .ram_waddr_o       (ram_waddr),
    .ram_wdata_o       (ram_wdata),
    .ram_re_o          (ram_re),
    .ram_raddr_o       (ram_raddr),
    .ram_rdata_i       (ram_rdata)
  );

  sws_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (emit_req),
    .ready_o          (emit_ready),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_kind_o       (out_kind_o),
    .seq_number_o     (seq_number_o),
    .packet_payload_o (packet_payload_o),
    .accepted_o       (accepted_o),
    .last_result_o    (last_result_o)
  );

endmodule
